// ----- hw/rtl/mre_pkg.sv -----
// Package for the mouse report encoder: payload structs, queue descriptor,
// character codes and the decimal digit step used by the front end.
// No dependencies.
`timescale 1ns / 1ps

package mre_pkg;

  localparam logic [1:0] EV_PRESS   = 2'd0;
  localparam logic [1:0] EV_RELEASE = 2'd1;
  localparam logic [1:0] EV_MOTION  = 2'd2;

  localparam logic CFG_X10 = 1'b0;
  localparam logic CFG_SGR = 1'b1;

  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_BRK    = 8'h5B;  // '['
  localparam logic [7:0] CH_UP_M   = 8'h4D;  // 'M'
  localparam logic [7:0] CH_LO_M   = 8'h6D;  // 'm'
  localparam logic [7:0] CH_LT     = 8'h3C;  // '<'
  localparam logic [7:0] CH_SEMI   = 8'h3B;  // ';'
  localparam logic [7:0] CH_ZERO   = 8'h30;  // '0'
  localparam logic [7:0] LEG_OFS   = 8'd32;
  localparam logic [7:0] LEG_CLAMP = 8'd223;
  localparam logic [7:0] CB_WHEEL  = 8'd64;
  localparam logic [7:0] CB_EXTRA  = 8'd128;
  localparam logic [7:0] CB_MOTION = 8'd32;

  typedef struct packed {
    logic [3:0]  button;
    logic [2:0]  modifiers;
    logic [11:0] column;
    logic [11:0] row;
    logic [1:0]  event_kind;
  } mre_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } mre_out_t;

  typedef struct packed {
    logic x10_mode;
    logic sgr_encoding;
  } mre_cfg_t;

  // Decimal digits, element 0 is the thousands digit, element 3 the ones digit.
  typedef logic [3:0][3:0] dig4_t;

  // One classified event, ready for the byte sequencer.
  typedef struct packed {
    logic       sgr;
    logic       rel;
    logic [7:0] cb_byte;
    logic [7:0] cx_byte;
    logic [7:0] cy_byte;
    dig4_t      cb_dig;
    dig4_t      cx_dig;
    dig4_t      cy_dig;
    logic [1:0] cb_start;
    logic [1:0] cx_start;
    logic [1:0] cy_start;
  } mre_cmd_t;

  typedef struct packed {
    logic [3:0]  dig;
    logic [11:0] rem;
  } dstep_t;

  // One decimal digit at a constant scale: parallel compares, then subtract.
  function automatic dstep_t dec_step(input logic [11:0] v, input logic [11:0] scale);
    dstep_t r;
    r.dig = '0;
    for (int k = 1; k < 10; k++) begin
      if (32'(v) >= 32'(k) * 32'(scale)) r.dig = 4'(k);
    end
    r.rem = v - 12'(32'(r.dig) * 32'(scale));
    return r;
  endfunction

  // Position of the first digit to print (no leading zeros, at least one digit).
  function automatic logic [1:0] lead_pos(input dig4_t d);
    logic [1:0] p;
    if (d[0] != 4'd0)      p = 2'd0;
    else if (d[1] != 4'd0) p = 2'd1;
    else if (d[2] != 4'd0) p = 2'd2;
    else                   p = 2'd3;
    return p;
  endfunction

endpackage

// ----- hw/rtl/mouse_report_encoder.sv -----
// Mouse report encoder, top level: configuration registers, front end,
// descriptor queue and byte sequencer. Depends on mre_pkg and the mre_* modules.
//
// Usage:
//   in_*  : one mouse event per accepted item (valid high, stall low).
//   out_* : the escape sequence, one byte per item, last set on the final byte.
//   cfg_* : cfg_we writes cfg_wdata to register cfg_index (0 x10_mode,
//           1 sgr_encoding); write only while the block is idle.
// The first byte of an event passes three front stages, the queue and the
//   output register.
// Throughput: one byte per cycle from the sequencer while out_stall is low; an
//   event is 6 bytes in X10 or normal mode and 9 to 17 bytes in SGR mode.
//   Events rejected by X10 produce no bytes but still take a front slot.
// The front end accepts an event every cycle until the two-entry queue is full
//   and its last stage holds an event, then raises in_stall.
// When out_stall is high the output byte holds and the sequencer waits.
// Reset clears both registers to 0 and empties the pipeline and queue.
`timescale 1ns / 1ps

module mouse_report_encoder import mre_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_we,
  input  logic     cfg_index,
  input  logic     cfg_wdata,
  input  logic     in_valid,
  output logic     in_stall,
  input  mre_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output mre_out_t out_data
);

  mre_cfg_t cfg_r;
  mre_cmd_t push_data, head;
  logic     push, full, pop, not_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_X10: cfg_r.x10_mode     <= cfg_wdata;
        CFG_SGR: cfg_r.sgr_encoding <= cfg_wdata;
        default: cfg_r <= cfg_r;
      endcase
    end
  end

  mre_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (full),
    .q_push   (push),
    .q_data   (push_data)
  );

  mre_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  mre_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (not_empty),
    .q_head    (head),
    .q_pop     (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- hw/rtl/mre_front.sv -----
// Front end of the mouse report encoder: accepts events, classifies them and
// converts coordinates to decimal over three stages. Depends on mre_pkg.
`timescale 1ns / 1ps

module mre_front import mre_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic     clk,
  input  logic     rst_n,
  input  mre_cfg_t cfg,
  input  logic     in_valid,
  output logic     in_stall,
  input  mre_in_t  in_data,
  input  logic     q_full,
  output logic     q_push,
  output mre_cmd_t q_data
);

  localparam int CW = (COORD_BITS < 12) ? COORD_BITS : 12;
  localparam logic [11:0] CMASK = 12'((1 << CW) - 1);

  typedef struct packed {
    logic        sgr;
    logic        rel;
    logic [7:0]  cbb;
    logic [7:0]  cxb;
    logic [7:0]  cyb;
    logic [7:0]  cb;
    logic [11:0] cx;
    logic [11:0] cy;
  } s1_t;

  typedef struct packed {
    logic       sgr;
    logic       rel;
    logic [7:0] cbb;
    logic [7:0] cxb;
    logic [7:0] cyb;
    logic [7:0] cb;
    logic [3:0] cx_k;
    logic [9:0] cx_r;
    logic [3:0] cy_k;
    logic [9:0] cy_r;
  } s2_t;

  typedef struct packed {
    logic       sgr;
    logic       rel;
    logic [7:0] cbb;
    logic [7:0] cxb;
    logic [7:0] cyb;
    logic [3:0] cx_k;
    logic [3:0] cy_k;
    logic [3:0] cb_h;
    logic [3:0] cx_h;
    logic [3:0] cy_h;
    logic [6:0] cb_r;
    logic [6:0] cx_r;
    logic [6:0] cy_r;
  } s3_t;

  logic s1_v_r, s2_v_r, s3_v_r;
  s1_t  s1_r, s1_nxt;
  s2_t  s2_r, s2_nxt;
  s3_t  s3_r, s3_nxt;
  logic en, keep;
  logic [7:0]  base, cb;
  logic [11:0] cx, cy;
  dstep_t k_cx, k_cy, h_cb, h_cx, h_cy, t_cb, t_cx, t_cy;
  dig4_t  cb_dig, cx_dig, cy_dig;

  // All stages move together; hold everything while the queue is full and stage 3 holds an event.
  assign en       = !(s3_v_r && q_full);
  assign in_stall = !en;
  assign q_push   = s3_v_r && !q_full;

  // Stage 1: button code, legacy bytes, masked coordinates
  always_comb begin
    cx = in_data.column & CMASK;
    cy = in_data.row & CMASK;

    if (cfg.x10_mode) begin
      keep = (in_data.event_kind == EV_PRESS) && (in_data.button inside {[4'd1:4'd5]});
    end else begin
      keep = 1'b1;
    end

    if (!cfg.x10_mode && !cfg.sgr_encoding && in_data.event_kind == EV_RELEASE) begin
      base = 8'd3;
    end else if (in_data.button inside {[4'd1:4'd3]}) begin
      base = 8'(in_data.button) - 8'd1;
    end else if (in_data.button inside {[4'd4:4'd7]}) begin
      base = CB_WHEEL + 8'(in_data.button) - 8'd4;
    end else if (in_data.button inside {[4'd8:4'd11]}) begin
      base = CB_EXTRA + 8'(in_data.button) - 8'd8;
    end else begin
      base = 8'd0;
    end

    cb = base;
    if (!cfg.x10_mode) begin
      cb = cb | {3'd0, in_data.modifiers, 2'd0};
      if (in_data.event_kind == EV_MOTION) cb = cb | CB_MOTION;
    end

    s1_nxt.sgr = !cfg.x10_mode && cfg.sgr_encoding;
    s1_nxt.rel = (in_data.event_kind == EV_RELEASE);
    s1_nxt.cb  = cb;
    s1_nxt.cx  = cx;
    s1_nxt.cy  = cy;
    s1_nxt.cbb = cb + LEG_OFS;
    // X10 wraps modulo 256, normal mode clamps first
    s1_nxt.cxb = (cfg.x10_mode || cx <= 12'(LEG_CLAMP)) ? cx[7:0] + LEG_OFS
                                                         : LEG_CLAMP + LEG_OFS;
    s1_nxt.cyb = (cfg.x10_mode || cy <= 12'(LEG_CLAMP)) ? cy[7:0] + LEG_OFS
                                                         : LEG_CLAMP + LEG_OFS;
  end

  // Stage 2: thousands digit
  always_comb begin
    k_cx = dec_step(s1_r.cx, 12'd1000);
    k_cy = dec_step(s1_r.cy, 12'd1000);
    s2_nxt.sgr  = s1_r.sgr;
    s2_nxt.rel  = s1_r.rel;
    s2_nxt.cbb  = s1_r.cbb;
    s2_nxt.cxb  = s1_r.cxb;
    s2_nxt.cyb  = s1_r.cyb;
    s2_nxt.cb   = s1_r.cb;
    s2_nxt.cx_k = k_cx.dig;
    s2_nxt.cx_r = k_cx.rem[9:0];
    s2_nxt.cy_k = k_cy.dig;
    s2_nxt.cy_r = k_cy.rem[9:0];
  end

  // Stage 3: hundreds digit
  always_comb begin
    h_cb = dec_step({4'd0, s2_r.cb}, 12'd100);
    h_cx = dec_step({2'd0, s2_r.cx_r}, 12'd100);
    h_cy = dec_step({2'd0, s2_r.cy_r}, 12'd100);
    s3_nxt.sgr  = s2_r.sgr;
    s3_nxt.rel  = s2_r.rel;
    s3_nxt.cbb  = s2_r.cbb;
    s3_nxt.cxb  = s2_r.cxb;
    s3_nxt.cyb  = s2_r.cyb;
    s3_nxt.cx_k = s2_r.cx_k;
    s3_nxt.cy_k = s2_r.cy_k;
    s3_nxt.cb_h = h_cb.dig;
    s3_nxt.cx_h = h_cx.dig;
    s3_nxt.cy_h = h_cy.dig;
    s3_nxt.cb_r = h_cb.rem[6:0];
    s3_nxt.cx_r = h_cx.rem[6:0];
    s3_nxt.cy_r = h_cy.rem[6:0];
  end

  // Queue entry: tens and ones digits, leading-digit positions
  always_comb begin
    t_cb = dec_step({5'd0, s3_r.cb_r}, 12'd10);
    t_cx = dec_step({5'd0, s3_r.cx_r}, 12'd10);
    t_cy = dec_step({5'd0, s3_r.cy_r}, 12'd10);

    cb_dig[0] = 4'd0;
    cb_dig[1] = s3_r.cb_h;
    cb_dig[2] = t_cb.dig;
    cb_dig[3] = t_cb.rem[3:0];
    cx_dig[0] = s3_r.cx_k;
    cx_dig[1] = s3_r.cx_h;
    cx_dig[2] = t_cx.dig;
    cx_dig[3] = t_cx.rem[3:0];
    cy_dig[0] = s3_r.cy_k;
    cy_dig[1] = s3_r.cy_h;
    cy_dig[2] = t_cy.dig;
    cy_dig[3] = t_cy.rem[3:0];

    q_data.sgr      = s3_r.sgr;
    q_data.rel      = s3_r.rel;
    q_data.cb_byte  = s3_r.cbb;
    q_data.cx_byte  = s3_r.cxb;
    q_data.cy_byte  = s3_r.cyb;
    q_data.cb_dig   = cb_dig;
    q_data.cx_dig   = cx_dig;
    q_data.cy_dig   = cy_dig;
    q_data.cb_start = lead_pos(cb_dig);
    q_data.cx_start = lead_pos(cx_dig);
    q_data.cy_start = lead_pos(cy_dig);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (en) begin
      // drop events that X10 does not report
      s1_v_r <= in_valid && keep;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
    end
  end

endmodule

// ----- hw/rtl/mre_queue.sv -----
// Two-entry descriptor queue between the front end and the byte sequencer.
// Depends on mre_pkg.
`timescale 1ns / 1ps

module mre_queue import mre_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  mre_cmd_t push_data,
  output logic     full,
  input  logic     pop,
  output logic     not_empty,
  output mre_cmd_t head
);

  mre_cmd_t   mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop)      cnt_nxt = cnt_r + 2'd1;
    else if (pop && !push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

endmodule

// ----- hw/rtl/mre_back.sv -----
// Byte sequencer of the mouse report encoder (needs mre_pkg): walks one queued
// descriptor, sending one byte per unstalled cycle through an output register.
`timescale 1ns / 1ps

module mre_back import mre_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_valid,
  input  mre_cmd_t q_head,
  output logic     q_pop,
  output logic     out_valid,
  input  logic     out_stall,
  output mre_out_t out_data
);

  localparam logic [3:0] P_ESC  = 4'd0;
  localparam logic [3:0] P_BRK  = 4'd1;
  localparam logic [3:0] P_LEAD = 4'd2;
  localparam logic [3:0] P_CB   = 4'd3;
  localparam logic [3:0] P_SEP1 = 4'd4;
  localparam logic [3:0] P_CX   = 4'd5;
  localparam logic [3:0] P_SEP2 = 4'd6;
  localparam logic [3:0] P_CY   = 4'd7;
  localparam logic [3:0] P_TERM = 4'd8;

  logic [3:0] phase_r, phase_nxt;
  logic [1:0] d_r, d_nxt;
  logic       out_valid_r;
  mre_out_t   out_data_r;
  logic       load, take, last;
  logic [7:0] byte_val;
  logic [3:0] dig;

  assign load      = !out_valid_r || !out_stall;
  assign take      = load && q_valid;
  assign q_pop     = take && last;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    byte_val  = CH_ESC;
    last      = 1'b0;
    phase_nxt = phase_r;
    d_nxt     = d_r;
    dig       = q_head.cb_dig[d_r];

    case (phase_r)
      P_ESC: begin
        byte_val  = CH_ESC;
        phase_nxt = P_BRK;
      end
      P_BRK: begin
        byte_val  = CH_BRK;
        phase_nxt = P_LEAD;
      end
      P_LEAD: begin
        byte_val  = q_head.sgr ? CH_LT : CH_UP_M;
        phase_nxt = P_CB;
        d_nxt     = q_head.cb_start;
      end
      P_CB: begin
        dig = q_head.cb_dig[d_r];
        if (q_head.sgr) begin
          byte_val = CH_ZERO + {4'd0, dig};
          if (d_r == 2'd3) phase_nxt = P_SEP1;
          else             d_nxt = d_r + 2'd1;
        end else begin
          byte_val  = q_head.cb_byte;
          phase_nxt = P_CX;
        end
      end
      P_SEP1: begin
        byte_val  = CH_SEMI;
        phase_nxt = P_CX;
        d_nxt     = q_head.cx_start;
      end
      P_CX: begin
        dig = q_head.cx_dig[d_r];
        if (q_head.sgr) begin
          byte_val = CH_ZERO + {4'd0, dig};
          if (d_r == 2'd3) phase_nxt = P_SEP2;
          else             d_nxt = d_r + 2'd1;
        end else begin
          byte_val  = q_head.cx_byte;
          phase_nxt = P_CY;
        end
      end
      P_SEP2: begin
        byte_val  = CH_SEMI;
        phase_nxt = P_CY;
        d_nxt     = q_head.cy_start;
      end
      P_CY: begin
        dig = q_head.cy_dig[d_r];
        if (q_head.sgr) begin
          byte_val = CH_ZERO + {4'd0, dig};
          if (d_r == 2'd3) phase_nxt = P_TERM;
          else             d_nxt = d_r + 2'd1;
        end else begin
          // legacy sequence ends on the row byte
          byte_val  = q_head.cy_byte;
          last      = 1'b1;
          phase_nxt = P_ESC;
        end
      end
      P_TERM: begin
        byte_val  = q_head.rel ? CH_LO_M : CH_UP_M;
        last      = 1'b1;
        phase_nxt = P_ESC;
      end
      default: begin
        byte_val  = CH_ESC;
        phase_nxt = P_ESC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= P_ESC;
      d_r         <= 2'd0;
    end else begin
      if (load) out_valid_r <= q_valid;
      if (take) begin
        phase_r <= phase_nxt;
        d_r     <= d_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r.out_byte <= byte_val;
      out_data_r.last     <= last;
    end
  end

endmodule
